// ----- hdl/jse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, character codes and helpers for the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int JSE_FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_LIT = 2'd0,
        CMD_ESC = 2'd1,
        CMD_UNI = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] data;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_beat_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
        begin
            r = 8'h30 + {4'h0, v};
        end
        else
        begin
            r = 8'h57 + {4'h0, v};
        end
        return r;
    endfunction

    // four leading hex digits, minimal width of at least four
    function automatic logic [15:0] leading_digits(input logic [30:0] cp);
        logic [31:0] w;
        logic [2:0]  hi;
        logic [15:0] r;
        w  = {1'b0, cp};
        hi = 3'd3;
        for (int i = 4; i < 8; i++)
        begin
            if (w[4*i +: 4] != 4'h0)
            begin
                hi = 3'(i);
            end
        end
        case (hi)
            3'd7:    r = w[31:16];
            3'd6:    r = w[27:12];
            3'd5:    r = w[23:8];
            3'd4:    r = w[19:4];
            default: r = w[15:0];
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/jse_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jse_front
// Accepts input bytes, tracks UTF-8 sequences and queues output commands.
// ----------------------------------------------------------------------------
module jse_front
    import jse_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic      end_of_string,
    input  wire logic      fifo_full,
    output cmd_beat_t      push
);

    logic [2:0]  pending_reg, pending_next;
    logic [30:0] cp_reg, cp_next;
    logic [30:0] cp_shift;
    logic        accept;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && !fifo_full;
    assign cp_shift = {cp_reg[24:0], in_byte[5:0]};

    always_comb
    begin
        pending_next  = pending_reg;
        cp_next       = cp_reg;
        push.valid    = 1'b0;
        push.cmd.kind = CMD_LIT;
        push.cmd.data = {8'h00, in_byte};
        if (accept)
        begin
            if (pending_reg != 3'd0)
            begin
                pending_next = pending_reg - 3'd1;
                if (pending_reg == 3'd1)
                begin
                    push.valid    = 1'b1;
                    push.cmd.kind = CMD_UNI;
                    push.cmd.data = leading_digits(cp_shift);
                    cp_next       = '0;
                end
                else
                begin
                    cp_next = cp_shift;
                end
            end
            else
            begin
                unique case (in_byte) inside
                    CH_QUOTE, CH_BSLASH:
                    begin
                        push.valid    = 1'b1;
                        push.cmd.kind = CMD_ESC;
                    end
                    CH_CR:
                    begin
                        push.valid    = 1'b1;
                        push.cmd.kind = CMD_ESC;
                        push.cmd.data = {8'h00, CH_LOW_R};
                    end
                    CH_LF:
                    begin
                        push.valid    = 1'b1;
                        push.cmd.kind = CMD_ESC;
                        push.cmd.data = {8'h00, CH_LOW_N};
                    end
                    CH_TAB:
                    begin
                        push.valid    = 1'b1;
                        push.cmd.kind = CMD_ESC;
                        push.cmd.data = {8'h00, CH_LOW_T};
                    end
                    CH_BS:
                    begin
                        push.valid    = 1'b1;
                        push.cmd.kind = CMD_ESC;
                        push.cmd.data = {8'h00, CH_LOW_B};
                    end
                    CH_FF:
                    begin
                        push.valid    = 1'b1;
                        push.cmd.kind = CMD_ESC;
                        push.cmd.data = {8'h00, CH_LOW_F};
                    end
                    default:
                    begin
                        if (in_byte >= CH_PRINT_LO && in_byte <= CH_PRINT_HI)
                        begin
                            push.valid = 1'b1;
                        end
                        else if ((in_byte & 8'hE0) == 8'hC0)
                        begin
                            cp_next      = {26'd0, in_byte[4:0]};
                            pending_next = 3'd1;
                        end
                        else if ((in_byte & 8'hF0) == 8'hE0)
                        begin
                            cp_next      = {27'd0, in_byte[3:0]};
                            pending_next = 3'd2;
                        end
                        else if ((in_byte & 8'hF8) == 8'hF0)
                        begin
                            cp_next      = {28'd0, in_byte[2:0]};
                            pending_next = 3'd3;
                        end
                        else if ((in_byte & 8'hFC) == 8'hF8)
                        begin
                            cp_next      = {29'd0, in_byte[1:0]};
                            pending_next = 3'd4;
                        end
                        else if ((in_byte & 8'hFE) == 8'hFC)
                        begin
                            cp_next      = {30'd0, in_byte[0]};
                            pending_next = 3'd5;
                        end
                    end
                endcase
            end
            if (end_of_string)
            begin
                pending_next = 3'd0;
                cp_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
            cp_reg      <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            cp_reg      <= cp_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/jse_cmd_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jse_cmd_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module jse_cmd_fifo
    import jse_pkg::*;
#(
    parameter int DEPTH = JSE_FIFO_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_beat_t push,
    input  wire logic      pop,
    output logic           full,
    output cmd_beat_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push.valid && full && !pop))
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head.valid))
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");

endmodule
`default_nettype wire

// ----- hdl/jse_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jse_back
// Expands queued commands into output bytes, one per cycle while not stalled.
// ----------------------------------------------------------------------------
module jse_back
    import jse_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_beat_t head,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic [7:0]     out_byte,
    output logic           run_last
);

    logic [2:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       load;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign load      = head.valid && (!out_valid_reg || out_ready);
    assign pop       = load && cur_last;

    always_comb
    begin
        cur_byte = head.cmd.data[7:0];
        cur_last = 1'b1;
        unique case (head.cmd.kind)
            CMD_LIT:
            begin
                cur_byte = head.cmd.data[7:0];
                cur_last = 1'b1;
            end
            CMD_ESC:
            begin
                cur_byte = (pos_reg == 3'd0) ? CH_BSLASH : head.cmd.data[7:0];
                cur_last = (pos_reg != 3'd0);
            end
            CMD_UNI:
            begin
                cur_last = (pos_reg == 3'd5);
                case (pos_reg)
                    3'd0:    cur_byte = CH_BSLASH;
                    3'd1:    cur_byte = CH_LOW_U;
                    3'd2:    cur_byte = hex_char(head.cmd.data[15:12]);
                    3'd3:    cur_byte = hex_char(head.cmd.data[11:8]);
                    3'd4:    cur_byte = hex_char(head.cmd.data[7:4]);
                    default: cur_byte = hex_char(head.cmd.data[3:0]);
                endcase
            end
            default:
            begin
                cur_byte = head.cmd.data[7:0];
                cur_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            pos_next       = cur_last ? 3'd0 : pos_reg + 3'd1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= cur_byte;
            run_last_reg <= cur_last;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 3'd5)
        else $error("byte position out of range");
    a_pop_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (pos_reg == 3'd0))
        else $error("position not cleared after last byte");
    a_load_shows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("loaded byte not presented");

endmodule
`default_nettype wire

// ----- hdl/json_string_escaper.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_escaper
// Streams string bytes in and emits their JSON-escaped text.
// ----------------------------------------------------------------------------
// channel  direction  handshake                payload
// input    in         in_valid / in_ready      in_byte, end_of_string
// output   out        out_valid / out_ready    out_byte, run_last
//
// an input beat is taken every cycle while the command queue has room
// the output side sends one byte per cycle while out_ready allows; an input byte
// produces 1 output byte plain, 2 escaped, 6 for a completed code point
// the worst sustained ratio is three output bytes per input byte, on two-byte sequences
// reset clears the sequence state, the queue and the output valid flag
// either side may stall without losing beats; the queue absorbs the slack
// ----------------------------------------------------------------------------
module json_string_escaper
    import jse_pkg::*;
#(
    parameter int FIFO_DEPTH = JSE_FIFO_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_string,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            run_last
);

    cmd_beat_t push;
    cmd_beat_t head;
    logic      fifo_full;
    logic      pop;

    jse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .fifo_full     (fifo_full),
        .push          (push)
    );

    jse_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (fifo_full),
        .head  (head)
    );

    jse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule
`default_nettype wire
